// ----- sv/wmf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared sizes, types and register codes of the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int WINDOW     = 3;
  localparam int HALF       = WINDOW / 2;
  localparam int TAPS       = WINDOW * WINDOW;
  localparam int MID        = TAPS / 2;
  localparam int LINES      = WINDOW - 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int LINE_W     = PIX_W * LINES;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 13;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W     = $clog2(MAX_HEIGHT);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2 * HALF + 2);
  localparam int LIN_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF * MAX_WIDTH + HALF + 1);

  localparam int WIDTH_RESET  = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int HEIGHT_RESET = 480;
  localparam int THR_RESET    = HALF * WIDTH_RESET + HALF;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef pix_t [WINDOW-1:0] col_t;
  typedef col_t [WINDOW-1:0] win_t;
  typedef logic [WINDOW-1:0] mask_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

// ----- sv/wmf_ram.sv -----
// ----------------------------------------------------------------------------
// wmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/wmf_col_cell.sv -----
// ----------------------------------------------------------------------------
// wmf_col_cell
// One column of the sliding window; hands its column to the next cell on shift.
// ----------------------------------------------------------------------------
module wmf_col_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  wmf_pkg::col_t col_in,
  output wmf_pkg::col_t col_out
);

  wmf_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

// ----- sv/wmf_median.sv -----
// ----------------------------------------------------------------------------
// wmf_median
// Rank stage: stable rank of every window tap, register taps and the one-hot
// pick of the middle rank, then select the median.
// ----------------------------------------------------------------------------
module wmf_median (
  input  logic          clk,
  input  logic          load,
  input  wmf_pkg::win_t win,
  output wmf_pkg::pix_t median
);

  wmf_pkg::pix_t                 flat     [wmf_pkg::TAPS];
  wmf_pkg::pix_t                 vals_r   [wmf_pkg::TAPS];
  logic [wmf_pkg::TAPS-1:0]      below    [wmf_pkg::TAPS];
  logic [wmf_pkg::TAPS-1:0]      sel_nxt;
  logic [wmf_pkg::TAPS-1:0]      sel_r;

  always_comb begin
    for (int c = 0; c < wmf_pkg::WINDOW; c++) begin
      for (int r = 0; r < wmf_pkg::WINDOW; r++) begin
        flat[c * wmf_pkg::WINDOW + r] = win[c][r];
      end
    end
  end

  // ties broken by tap index so every rank is taken exactly once
  always_comb begin
    for (int i = 0; i < wmf_pkg::TAPS; i++) begin
      below[i] = '0;
      for (int j = 0; j < wmf_pkg::TAPS; j++) begin
        if (j < i) begin
          below[i][j] = (flat[j] <= flat[i]);
        end else if (j > i) begin
          below[i][j] = (flat[j] < flat[i]);
        end
      end
      sel_nxt[i] = ($countones(below[i]) == wmf_pkg::MID);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vals_r <= flat;
      sel_r  <= sel_nxt;
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < wmf_pkg::TAPS; i++) begin
      median = median | (sel_r[i] ? vals_r[i] : '0);
    end
  end

endmodule

// ----- sv/window_median_filter.sv -----
// ----------------------------------------------------------------------------
// window_median_filter
// Streaming WINDOW x WINDOW median filter for 8-bit grey frames in raster order.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while in_ready is high and, once the pipeline
// is full, one median is delivered per clock unless out_ready holds it back;
// a transfer reaches its result through the line RAM read, window shift, rank
// stage and output register. Each output is the median of the unfiltered
// neighborhood, with neighbors outside the image read as zero. Output (r,c)
// appears with input raster index r*W + c + HALF*W + HALF, so after the W*H
// frame pixels send HALF*W + HALF items with filler set; the final output
// carries last_of_frame and the next transfer starts a new frame. A filler
// item inside the frame is dropped. Writing image_width or image_height
// restarts the frame; write only while idle. A width of 0 acts as 1 and
// values above MAX_WIDTH are clamped; the same holds for height against
// 4096. The line RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module window_median_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_pixel,
  input  logic                          in_filler,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_filtered_pixel,
  output logic                          out_last_of_frame
);

  localparam int WID_W  = wmf_pkg::WID_W;
  localparam int HGT_W  = wmf_pkg::HGT_W;
  localparam int COL_W  = wmf_pkg::COL_W;
  localparam int ROW_W  = wmf_pkg::ROW_W;
  localparam int OROW_W = wmf_pkg::OROW_W;
  localparam int LIN_W  = wmf_pkg::LIN_W;
  localparam int CFG_W  = wmf_pkg::CFG_W;

  function automatic logic [WID_W-1:0] clamp_width(
    input logic [wmf_pkg::CFG_WID_W-1:0] v
  );
    logic [CFG_W-1:0] ext;
    ext = CFG_W'(v);
    if (v == '0) return WID_W'(1);
    if (ext > CFG_W'(wmf_pkg::MAX_WIDTH)) return WID_W'(wmf_pkg::MAX_WIDTH);
    return WID_W'(v);
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(
    input logic [wmf_pkg::CFG_HGT_W-1:0] v
  );
    logic [CFG_W-1:0] ext;
    ext = CFG_W'(v);
    if (v == '0) return HGT_W'(1);
    if (ext > CFG_W'(wmf_pkg::MAX_HEIGHT)) return HGT_W'(wmf_pkg::MAX_HEIGHT);
    return HGT_W'(v);
  endfunction

  // configuration and position counters
  logic [WID_W-1:0]  w_r, w_nxt;
  logic [HGT_W-1:0]  h_r, h_nxt;
  logic [LIN_W-1:0]  thr_r, thr_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [LIN_W-1:0]  in_lin_r, in_lin_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  // pipeline stages
  logic                   s1_valid_r, s1_emit_r, s1_last_r, s1_byp_r;
  wmf_pkg::pix_t          s1_pixel_r;
  logic [COL_W-1:0]       s1_addr_r;
  wmf_pkg::mask_t         s1_vmask_r, s1_hmask_r;
  logic [wmf_pkg::LINE_W-1:0] s1_byp_data_r;
  logic                   s2_valid_r, s2_last_r;
  wmf_pkg::mask_t         s2_hmask_r;
  logic                   s3_valid_r, s3_last_r;
  logic                   out_valid_r, out_last_r;
  wmf_pkg::pix_t          out_pixel_r;

  logic accept, in_frame, drop, take, emit, last;
  logic out_free, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free;
  logic [WID_W:0]  col_inc, ocol_inc, cpos;
  logic [HGT_W:0]  orow_inc;
  logic            col_wrap, ocol_wrap;
  wmf_pkg::mask_t  vmask, hmask;

  logic [wmf_pkg::LINE_W-1:0] ram_rdata, rd_lines, ram_wdata;
  wmf_pkg::col_t col_raw, col_masked;
  wmf_pkg::win_t cells, win_masked;
  wmf_pkg::pix_t median;

  // stage handshakes
  assign out_free = !out_valid_r || out_ready;
  assign s3_move  = s3_valid_r && out_free;
  assign s3_free  = !s3_valid_r || out_free;
  assign s2_move  = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_move  = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  assign accept   = in_valid && in_ready;
  assign in_frame = in_row_r < ROW_W'(h_r);
  assign drop     = in_frame && in_filler;
  assign take     = accept && !drop;
  assign emit     = in_lin_r >= thr_r;

  assign col_inc   = (WID_W+1)'(in_col_r) + 1'b1;
  assign col_wrap  = col_inc >= (WID_W+1)'(w_r);
  assign ocol_inc  = (WID_W+1)'(out_col_r) + 1'b1;
  assign ocol_wrap = ocol_inc >= (WID_W+1)'(w_r);
  assign orow_inc  = (HGT_W+1)'(out_row_r) + 1'b1;
  assign last      = emit && ocol_wrap && (orow_inc == (HGT_W+1)'(h_r));
  assign cpos      = (WID_W+1)'(out_col_r) + (WID_W+1)'(wmf_pkg::HALF);

  // row and column validity of the taps around the current positions
  always_comb begin
    for (int j = 0; j < wmf_pkg::WINDOW; j++) begin
      vmask[j] = (in_row_r >= ROW_W'(j)) &&
                 ((ROW_W+1)'(in_row_r) < (ROW_W+1)'(h_r) + (ROW_W+1)'(j));
      hmask[j] = (cpos >= (WID_W+1)'(j)) &&
                 ((cpos - (WID_W+1)'(j)) < (WID_W+1)'(w_r));
    end
  end

  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    thr_nxt     = thr_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    in_lin_nxt  = in_lin_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (cfg_we) begin
      unique case (wmf_pkg::cfg_reg_t'(cfg_index))
        wmf_pkg::REG_IMAGE_WIDTH: begin
          w_nxt   = clamp_width(cfg_wdata[wmf_pkg::CFG_WID_W-1:0]);
          thr_nxt = LIN_W'(w_nxt) * LIN_W'(wmf_pkg::HALF) + LIN_W'(wmf_pkg::HALF);
        end
        wmf_pkg::REG_IMAGE_HEIGHT: begin
          h_nxt = clamp_height(cfg_wdata[wmf_pkg::CFG_HGT_W-1:0]);
        end
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_lin_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      in_lin_nxt = in_lin_r + 1'b1;
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = COL_W'(col_inc);
      end
      if (emit) begin
        if (ocol_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = COL_W'(ocol_inc);
        end
      end
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        in_lin_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WID_W'(wmf_pkg::WIDTH_RESET);
      h_r       <= HGT_W'(wmf_pkg::HEIGHT_RESET);
      thr_r     <= LIN_W'(wmf_pkg::THR_RESET);
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_lin_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      thr_r     <= thr_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      in_lin_r  <= in_lin_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // line RAM: read at transfer, write back the shifted column as stage 1 leaves
  wmf_ram #(
    .WIDTH (wmf_pkg::LINE_W),
    .DEPTH (wmf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  assign rd_lines = s1_byp_r ? s1_byp_data_r : ram_rdata;

  always_comb begin
    col_raw[0] = s1_pixel_r;
    for (int j = 1; j < wmf_pkg::WINDOW; j++) begin
      col_raw[j] = rd_lines[(j-1)*wmf_pkg::PIX_W +: wmf_pkg::PIX_W];
    end
    for (int j = 0; j < wmf_pkg::WINDOW; j++) begin
      col_masked[j] = s1_vmask_r[j] ? col_raw[j] : '0;
    end
    for (int j = 0; j < wmf_pkg::LINES; j++) begin
      ram_wdata[j*wmf_pkg::PIX_W +: wmf_pkg::PIX_W] = col_raw[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pixel_r    <= in_pixel;
      s1_addr_r     <= in_col_r;
      s1_vmask_r    <= vmask;
      s1_hmask_r    <= hmask;
      s1_emit_r     <= emit;
      s1_last_r     <= last;
      s1_byp_r      <= s1_move && (s1_addr_r == in_col_r);
      s1_byp_data_r <= ram_wdata;
    end
  end

  // window: chain of column cells, newest column in cell 0
  for (genvar g = 0; g < wmf_pkg::WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      wmf_col_cell u_cell (
        .clk      (clk),
        .shift_en (s1_move),
        .col_in   (col_masked),
        .col_out  (cells[g])
      );
    end else begin : g_body
      wmf_col_cell u_cell (
        .clk      (clk),
        .shift_en (s1_move),
        .col_in   (cells[g-1]),
        .col_out  (cells[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r <= s1_emit_r;
    end else if (s2_move) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_hmask_r <= s1_hmask_r;
      s2_last_r  <= s1_last_r;
    end
  end

  always_comb begin
    for (int i = 0; i < wmf_pkg::WINDOW; i++) begin
      win_masked[i] = s2_hmask_r[i] ? cells[i] : '0;
    end
  end

  wmf_median u_median (
    .clk    (clk),
    .load   (s2_move),
    .win    (win_masked),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s2_move) begin
      s3_valid_r <= 1'b1;
    end else if (s3_move) begin
      s3_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_pixel_r <= median;
      out_last_r  <= s3_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_pixel = out_pixel_r;
  assign out_last_of_frame  = out_last_r;

endmodule

// ----- verif/wmf_median_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmf_median_monitor
// Watches the pixel, result and register ports of the window median filter,
// keeps its own line store and raster counters, and predicts every median and
// frame-end flag. Each result transfer is compared against the oldest
// prediction; surplus results and wrong fields are counted as failures.
// ----------------------------------------------------------------------------
module wmf_median_monitor import wmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  pix_t                 in_pixel,
  input  logic                 in_filler,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  pix_t                 out_filtered_pixel,
  input  logic                 out_last_of_frame,
  output int                   miss_count,
  output int                   backlog
);

  localparam int SLOTS = WINDOW + 1;

  typedef struct packed {
    pix_t median;
    logic last;
  } median_t;

  median_t               median_q[$];
  pix_t                  row_mem [SLOTS*MAX_WIDTH];
  logic [CFG_WID_W-1:0]  width_reg;
  logic [CFG_HGT_W-1:0]  height_reg;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           out_pos;

  function automatic int unsigned cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned rows();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic pix_t neighbor(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return '0;
    return row_mem[(r % SLOTS) * MAX_WIDTH + c];
  endfunction

  function automatic pix_t window_median(int r, int c, int w, int h);
    pix_t taps [TAPS];
    pix_t v;
    int   n;
    int   j;
    int   dr;
    int   dc;
    n = 0;
    for (dr = -HALF; dr <= HALF; dr++) begin
      for (dc = -HALF; dc <= HALF; dc++) begin
        v = neighbor(r + dr, c + dc, w, h);
        j = n;
        while (j > 0 && taps[j-1] > v) begin
          taps[j] = taps[j-1];
          j--;
        end
        taps[j] = v;
        n++;
      end
    end
    return taps[MID];
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
  endfunction

  function automatic void take_pixel(pix_t px, logic fill);
    int unsigned w;
    int unsigned h;
    int unsigned area;
    int unsigned lin;
    int unsigned k;
    median_t     res;
    w    = cols();
    h    = rows();
    area = w * h;
    lin  = row_pos * w + col_pos;
    if (lin < area) begin
      // drop filler items while frame pixels are still due
      if (fill) return;
      row_mem[(row_pos % SLOTS) * MAX_WIDTH + col_pos] = px;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (lin < HALF * w + HALF) return;
    k          = out_pos;
    res.median = window_median(int'(k / w), int'(k % w), int'(w), int'(h));
    res.last   = (k + 1 >= area);
    median_q   = {median_q, res};
    out_pos++;
    if (res.last) restart_frame();
  endfunction

  always @(posedge clk) begin
    median_t want;
    if (!rst_n) begin
      width_reg  = CFG_WID_W'(WIDTH_RESET);
      height_reg = CFG_HGT_W'(HEIGHT_RESET);
      restart_frame();
      median_q.delete();
      miss_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("%0t: unexpected result transfer: median %0d last %0b",
                     $realtime, out_filtered_pixel, out_last_of_frame);
        end else begin
          want = median_q.pop_front();
          if (out_filtered_pixel !== want.median || out_last_of_frame !== want.last) begin
            miss_count++;
            if (miss_count <= 10)
              $display("%0t: result mismatch: expected median %0d last %0b, %s %0d last %0b",
                       $realtime, want.median, want.last, "got median",
                       out_filtered_pixel, out_last_of_frame);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_wdata[CFG_WID_W-1:0];
            restart_frame();
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_wdata[CFG_HGT_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_pixel(in_pixel, in_filler);
    end
    backlog <= median_q.size();
  end

endmodule

// ----- verif/tb_window_median_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_median_filter
// Stimulus and verdict for the window median filter. Directed frames cover
// extreme pixels, clamped geometry, filler inside a frame and pixels during
// drain; then the heads of frames at the largest geometries, then random small
// frames with random content, back-to-back frames and frames cut short by a
// register write. Both channels idle at random; the monitor predicts and
// compares.
// ----------------------------------------------------------------------------
module tb_window_median_filter;
  import wmf_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 400;
  localparam int HEAD_ITEMS    = 48;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pix_t                 in_pixel  = '0;
  logic                 in_filler = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_t                 out_filtered_pixel;
  logic                 out_last_of_frame;

  int miss_count;
  int backlog;
  int quiet    = 0;
  int in_calm  = 0;
  int out_calm = 0;
  int fed      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  window_median_filter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel           (in_pixel),
    .in_filler          (in_filler),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_pixel (out_filtered_pixel),
    .out_last_of_frame  (out_last_of_frame)
  );

  wmf_median_monitor u_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel           (in_pixel),
    .in_filler          (in_filler),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_pixel (out_filtered_pixel),
    .out_last_of_frame  (out_last_of_frame),
    .miss_count         (miss_count),
    .backlog            (backlog)
  );

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(16, 64);
    return $urandom_range(0, 6);
  endfunction

  function automatic int span(int prog, int top);
    if (prog == 0) return 1;
    if (prog > top) return top;
    return prog;
  endfunction

  function automatic pix_t pick_level(int style);
    case (style)
      1: begin
        case ($urandom_range(0, 2))
          0:       return 8'd0;
          1:       return 8'd255;
          default: return pix_t'($urandom);
        endcase
      end
      2:       return pix_t'($urandom_range(96, 127));
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input pix_t px, input logic fill);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_pixel  <= px;
    in_filler <= fill;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [CFG_WID_W-1:0] w,
                                input logic [CFG_HGT_W-1:0] h);
    logic [CFG_W-CFG_WID_W-1:0] junk;
    junk = (CFG_W-CFG_WID_W)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= {junk, w};
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // feed one frame plus its drain items; a cut frame stops early
  task automatic run_frame(input int w, input int h, input int style, input bit cut);
    int area;
    int total;
    int stop;
    int i;
    area  = w * h;
    total = area + HALF * w + HALF;
    stop  = cut ? $urandom_range(0, total - 1) : total;
    for (i = 0; i < stop; i++) begin
      if (i < area) begin
        if ($urandom_range(0, 11) == 0) send_item(pix_t'($urandom), 1'b1);
        send_item(pick_level(style), 1'b0);
      end else begin
        send_item(pix_t'($urandom), $urandom_range(0, 4) != 0);
      end
      fed++;
    end
  endtask

  // feed only the first pixels of a frame
  task automatic run_head(input int count, input int style);
    int i;
    for (i = 0; i < count; i++) begin
      send_item(pick_level(style), 1'b0);
      fed++;
    end
  endtask

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int  pw;
    int  ph;
    int  w;
    int  h;
    bit  cut;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_geometry(11'd3, 13'd2);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h7F, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'h12, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h80, 1'b0);
    quiesce();

    write_geometry(11'd0, 13'd0);
    send_item(8'd255, 1'b0);
    send_item(8'd3, 1'b1);
    send_item(8'd0, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'd128, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd7, 1'b1);
    quiesce();

    write_geometry(11'd2047, 13'd2);
    run_head(HEAD_ITEMS, 0);
    quiesce();
    write_geometry(11'd1, 13'd8191);
    run_head(HEAD_ITEMS, 1);

    fed = 0;
    cut = 1'b1;
    while (fed < RANDOM_ITEMS) begin
      if (cut || $urandom_range(0, 3) != 0) begin
        quiesce();
        case ($urandom_range(0, 19))
          0:       pw = 0;
          1, 2:    pw = $urandom_range(13, 64);
          default: pw = $urandom_range(1, 12);
        endcase
        ph = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        write_geometry(CFG_WID_W'(pw), CFG_HGT_W'(ph));
        w = span(pw, MAX_WIDTH);
        h = span(ph, MAX_HEIGHT);
      end
      cut = ($urandom_range(0, 9) == 0);
      run_frame(w, h, $urandom_range(0, 2), cut);
    end
    quiesce();

    if (miss_count == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
